>>> rtl/mp2d_pkg.sv
// shared constants, register map and a helper function of the 2-d max pooling block
package mp2d_pkg;

  // parameter defaults
  localparam int unsigned MAX_POOL_DEF     = 4;
  localparam int unsigned MAX_WIDTH_DEF    = 64;
  localparam int unsigned MAX_CHANNELS_DEF = 64;
  localparam int unsigned VALUE_BITS_DEF   = 16;

  // row count of one image is capped here
  localparam int unsigned HEIGHT_LIMIT = 64;
  localparam int unsigned ROW_W        = $clog2(HEIGHT_LIMIT);

  // apb register map, one word per register
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [2:0] REG_WIN_SIZE  = 3'd0;
  localparam logic [2:0] REG_STRIDE    = 3'd1;
  localparam logic [2:0] REG_IN_HEIGHT = 3'd2;
  localparam logic [2:0] REG_IN_WIDTH  = 3'd3;
  localparam logic [2:0] REG_CHANNELS  = 3'd4;

  // register reset values
  localparam logic [2:0] WIN_SIZE_RST  = 3'd2;
  localparam logic [2:0] STRIDE_RST    = 3'd2;
  localparam logic [6:0] IN_HEIGHT_RST = 7'd32;
  localparam logic [6:0] IN_WIDTH_RST  = 7'd32;
  localparam logic [6:0] CHANNELS_RST  = 7'd3;

  // inverse of an odd number modulo 2^32, newton iteration
  function automatic int unsigned odd_inverse(input int unsigned d);
    int unsigned inv;
    inv = d;
    for (int i = 0; i < 5; i++) begin
      inv = inv * (32'd2 - d * inv);
    end
    return inv;
  endfunction

endpackage

>>> rtl/max_pool_2d_stream.sv
// streaming 2-d max pooling over an hwc tensor with a column-wide row store
//
// usage: elements enter on the sample channel (in_valid_i / in_ready_o) in height,
// width, channel order, images back to back. each element that closes a pooling
// window (bottom-right corner, windows every stride rows and columns) yields one
// transfer on the result channel (out_valid_o / out_ready_i) carrying the window
// maximum for that channel; image_done_o marks the last result of an image.
// windows that would cross the right or bottom edge are never produced.
// sequence: an element that closes no window leaves the sequencer idle. an element that
// closes a window holds off the sample channel while the store is read one column (all
// pooled rows side by side) per cycle over the window columns, then the maximum is
// loaded into the output register; the result is visible the cycle after that load.
// a stalled receiver holds the result in the output register; new elements keep
// being taken until a second result is ready, which then waits for the register.
// reset clears the counters to the start of an image and loads register defaults;
// the row store is not cleared, every entry is written before it is read.
// configuration goes through the apb port (window size, stride, in_height,
// in_width, channels at byte offsets 0 to 16) while no element is in flight.
module max_pool_2d_stream #(
  parameter int unsigned MAX_POOL     = mp2d_pkg::MAX_POOL_DEF,
  parameter int unsigned MAX_WIDTH    = mp2d_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_CHANNELS = mp2d_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned VALUE_BITS   = mp2d_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // sample channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [VALUE_BITS-1:0]            sample_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [VALUE_BITS-1:0]            pooled_value_o,
  output logic                             image_done_o,
  // apb configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mp2d_pkg::PADDR_W-1:0]     paddr,
  input  logic [mp2d_pkg::PDATA_W-1:0]     pwdata,
  output logic [mp2d_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  // widths
  localparam int unsigned MP    = MAX_POOL;
  localparam int unsigned LW    = (MP > 1) ? $clog2(MP) : 1;       // row lane
  localparam int unsigned DW    = LW + 1;                          // lane distance
  localparam int unsigned PW    = $clog2(MP + 1);                  // latched pool size
  localparam int unsigned CW    = $clog2(MAX_WIDTH);               // column counter
  localparam int unsigned CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned RW    = mp2d_pkg::ROW_W;                 // row counter
  localparam int unsigned AW    = CW + CHW;                        // store address
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned NW0   = (CW > CHW) ? CW : CHW;
  localparam int unsigned NW    = ((NW0 > 7) ? NW0 : 7) + 2;       // compare width
  localparam int unsigned XW    = (CW > RW) ? CW : RW;             // stride test width

  // divisibility test constants for the odd strides
  localparam logic [XW-1:0] INV3 = XW'(mp2d_pkg::odd_inverse(3));
  localparam logic [XW-1:0] INV5 = XW'(mp2d_pkg::odd_inverse(5));
  localparam logic [XW-1:0] INV7 = XW'(mp2d_pkg::odd_inverse(7));
  localparam logic [XW-1:0] LIM3 = XW'((2 ** XW - 1) / 3);
  localparam logic [XW-1:0] LIM5 = XW'((2 ** XW - 1) / 5);
  localparam logic [XW-1:0] LIM7 = XW'((2 ** XW - 1) / 7);

  localparam logic [VALUE_BITS-1:0] MIN_VALUE = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // taking elements
  localparam logic [1:0] ST_READ = 2'd1;  // reading window columns
  localparam logic [1:0] ST_FIN  = 2'd2;  // last column merge, output load

  // x divisible by s, x*inv mod 2^n <= (2^n-1)/d for odd d
  function automatic logic stride_hit(input logic [XW-1:0] x, input logic [2:0] s);
    logic [XW-1:0] y;
    logic          hit;
    y = x >> 1;
    unique case (s)
      3'd2:    hit = ~x[0];
      3'd3:    hit = XW'(x * INV3) <= LIM3;
      3'd4:    hit = (x[1:0] == 2'd0);
      3'd5:    hit = XW'(x * INV5) <= LIM5;
      3'd6:    hit = ~x[0] && (XW'(y * INV3) <= LIM3);
      3'd7:    hit = XW'(x * INV7) <= LIM7;
      default: hit = 1'b1;
    endcase
    return hit;
  endfunction

  // configuration registers
  logic [2:0] win_size_q, stride_q;
  logic [6:0] in_height_q, in_width_q, channels_q;

  // stream position
  logic [RW-1:0]  row_q;
  logic [LW-1:0]  lane_q;   // row modulo MAX_POOL
  logic [CW-1:0]  col_q;
  logic [CHW-1:0] ch_q;

  // window job
  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         base_col_q;
  logic [CHW-1:0]        win_ch_q;
  logic [LW-1:0]         win_lane_q;
  logic [PW-1:0]         win_p_q;
  logic                  win_done_q;
  logic [LW-1:0]         j_q;
  logic                  rd_vld_q;
  logic [VALUE_BITS-1:0] best_q;

  // row store, one word holds a column of all pooled rows
  logic [MP-1:0][VALUE_BITS-1:0] mem [DEPTH];
  logic [MP-1:0][VALUE_BITS-1:0] rdata_q;

  // output register
  logic                  out_vld_q;
  logic [VALUE_BITS-1:0] out_val_q;
  logic                  out_done_q;

  logic [NW-1:0] p_eff, s_eff, h_eff, w_eff, c_eff;
  logic [NW-1:0] r1, c1;
  logic          in_fire, corner, done;
  logic          last_read, out_load;
  logic [MP-1:0] in_win;
  logic [VALUE_BITS-1:0] col_max, fin_max;
  logic [AW-1:0] waddr, raddr;
  logic          cfg_wr;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q  <= mp2d_pkg::WIN_SIZE_RST;
      stride_q    <= mp2d_pkg::STRIDE_RST;
      in_height_q <= mp2d_pkg::IN_HEIGHT_RST;
      in_width_q  <= mp2d_pkg::IN_WIDTH_RST;
      channels_q  <= mp2d_pkg::CHANNELS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        mp2d_pkg::REG_WIN_SIZE:  win_size_q  <= pwdata[2:0];
        mp2d_pkg::REG_STRIDE:    stride_q    <= pwdata[2:0];
        mp2d_pkg::REG_IN_HEIGHT: in_height_q <= pwdata[6:0];
        mp2d_pkg::REG_IN_WIDTH:  in_width_q  <= pwdata[6:0];
        mp2d_pkg::REG_CHANNELS:  channels_q  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      mp2d_pkg::REG_WIN_SIZE:  prdata = mp2d_pkg::PDATA_W'(win_size_q);
      mp2d_pkg::REG_STRIDE:    prdata = mp2d_pkg::PDATA_W'(stride_q);
      mp2d_pkg::REG_IN_HEIGHT: prdata = mp2d_pkg::PDATA_W'(in_height_q);
      mp2d_pkg::REG_IN_WIDTH:  prdata = mp2d_pkg::PDATA_W'(in_width_q);
      mp2d_pkg::REG_CHANNELS:  prdata = mp2d_pkg::PDATA_W'(channels_q);
      default:                 prdata = '0;
    endcase
  end

  // effective sizes: zero reads as one, oversize is capped
  always_comb begin
    if (win_size_q == 3'd0)                p_eff = NW'(1);
    else if (NW'(win_size_q) > NW'(MP))    p_eff = NW'(MP);
    else                                   p_eff = NW'(win_size_q);

    if (stride_q == 3'd0) s_eff = NW'(1);
    else                  s_eff = NW'(stride_q);

    if (in_height_q == 7'd0)                                   h_eff = NW'(1);
    else if (NW'(in_height_q) > NW'(mp2d_pkg::HEIGHT_LIMIT))   h_eff = NW'(mp2d_pkg::HEIGHT_LIMIT);
    else                                                       h_eff = NW'(in_height_q);

    if (in_width_q == 7'd0)                        w_eff = NW'(1);
    else if (NW'(in_width_q) > NW'(MAX_WIDTH))     w_eff = NW'(MAX_WIDTH);
    else                                           w_eff = NW'(in_width_q);

    if (channels_q == 7'd0)                        c_eff = NW'(1);
    else if (NW'(channels_q) > NW'(MAX_CHANNELS))  c_eff = NW'(MAX_CHANNELS);
    else                                           c_eff = NW'(channels_q);
  end

  // ---------------------------------------------------------------- window decision
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign r1 = NW'(row_q) + NW'(1);
  assign c1 = NW'(col_q) + NW'(1);

  // element closes a window when both window starts land on the stride grid
  assign corner = (r1 >= p_eff) && (c1 >= p_eff)
               && stride_hit(XW'(r1 - p_eff), s_eff[2:0])
               && stride_hit(XW'(c1 - p_eff), s_eff[2:0]);

  // last window of the image: last channel, and no further window fits below or to the right
  assign done = corner
             && (NW'(row_q) < h_eff) && (NW'(row_q) + s_eff >= h_eff)
             && (NW'(col_q) < w_eff) && (NW'(col_q) + s_eff >= w_eff)
             && (NW'(ch_q) + NW'(1) == c_eff);

  // ---------------------------------------------------------------- position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      lane_q <= '0;
      col_q  <= '0;
      ch_q   <= '0;
    end else if (in_fire) begin
      if (NW'(ch_q) + NW'(1) >= c_eff) begin
        ch_q <= '0;
        if (c1 >= w_eff) begin
          col_q <= '0;
          if (r1 >= h_eff) begin
            row_q  <= '0;
            lane_q <= '0;
          end else begin
            row_q  <= row_q + RW'(1);
            lane_q <= (lane_q == LW'(MP - 1)) ? '0 : lane_q + LW'(1);
          end
        end else begin
          col_q <= col_q + CW'(1);
        end
      end else begin
        ch_q <= ch_q + CHW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- row store
  assign waddr = {col_q, ch_q};
  assign raddr = {base_col_q + CW'(j_q), win_ch_q};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem[waddr][lane_q] <= sample_i;
    end
    if (state_q == ST_READ) begin
      rdata_q <= mem[raddr];
    end
  end

  // lanes of the pooled rows: distance back from the corner row below pool size
  always_comb begin
    logic [DW-1:0] lane_gap;
    for (int k = 0; k < MP; k++) begin
      if (win_lane_q >= LW'(k)) lane_gap = DW'(win_lane_q) - DW'(k);
      else                      lane_gap = DW'(win_lane_q) + DW'(MP) - DW'(k);
      in_win[k] = (NW'(lane_gap) < NW'(win_p_q));
    end
  end

  always_comb begin
    col_max = MIN_VALUE;
    for (int k = 0; k < MP; k++) begin
      if (in_win[k] && ($signed(rdata_q[k]) > $signed(col_max))) col_max = rdata_q[k];
    end
    fin_max = ($signed(col_max) > $signed(best_q)) ? col_max : best_q;
  end

  // ---------------------------------------------------------------- sequencer
  assign last_read = (PW'(j_q) + PW'(1) == win_p_q);
  assign out_load  = (state_q == ST_FIN) && (!out_vld_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire && corner) state_d = ST_READ;
      ST_READ: if (last_read)         state_d = ST_FIN;
      ST_FIN:  if (out_load)          state_d = ST_IDLE;
      default:                        state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      j_q      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_READ);
      if (in_fire)                    j_q <= '0;
      else if (state_q == ST_READ)    j_q <= j_q + LW'(1);
    end
  end

  // window job payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      base_col_q <= CW'(c1 - p_eff);
      win_ch_q   <= ch_q;
      win_lane_q <= lane_q;
      win_p_q    <= PW'(p_eff);
      win_done_q <= done;
      best_q     <= MIN_VALUE;
    end else if (state_q == ST_READ && rd_vld_q) begin
      best_q <= fin_max;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q  <= fin_max;
      out_done_q <= win_done_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign pooled_value_o = out_val_q;
  assign image_done_o   = out_done_q;

endmodule

>>> rtl/mp2d_checker.sv
// port-level checks of the 2-d max pooling block, bound to its top level
module mp2d_checker #(
  parameter int unsigned VALUE_BITS = mp2d_pkg::VALUE_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [VALUE_BITS-1:0] pooled_value_o,
  input logic                  image_done_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pooled_value_o)
                                    && $stable(image_done_o))
    else $error("result changed while stalled");

  // an offered sample is not withdrawn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("sample withdrawn before transfer");

  // the sample channel closes only after a sample transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("ready dropped without a sample transfer");

  // a new result needs at least the store read cycles after its sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o, 1)
                           && !$past(in_valid_i && in_ready_o, 2))
    else $error("result appeared too soon after a sample transfer");

endmodule

bind max_pool_2d_stream mp2d_checker #(.VALUE_BITS(VALUE_BITS)) u_mp2d_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .pooled_value_o (pooled_value_o),
  .image_done_o   (image_done_o)
);

>>> sim/tb_max_pool_2d_stream.sv
// self-checking testbench for the streaming 2-d max pooling block
module tb_max_pool_2d_stream;

  localparam int unsigned POOL_CAP      = mp2d_pkg::MAX_POOL_DEF;
  localparam int unsigned WIDTH_CAP     = mp2d_pkg::MAX_WIDTH_DEF;
  localparam int unsigned CHAN_CAP      = mp2d_pkg::MAX_CHANNELS_DEF;
  localparam int unsigned STRIDE_CAP    = 7;
  localparam int unsigned STORE_WORDS   = POOL_CAP * WIDTH_CAP * CHAN_CAP;
  localparam int unsigned PADDR_W       = mp2d_pkg::PADDR_W;
  localparam int unsigned PDATA_W       = mp2d_pkg::PDATA_W;
  // settle margin after the last expected result, above the longest window read
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS  = 1200;
  localparam int unsigned LONG_HOLD     = 400;

  // one expected pooled result
  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } pooled_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [15:0]          sample_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [15:0]          pooled_value_o;
  logic                 image_done_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  max_pool_2d_stream dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pooled_value_o (pooled_value_o),
    .image_done_o   (image_done_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // shadow copy of the block: registers, position counters and the row store
  logic [2:0]         reg_pool   = mp2d_pkg::WIN_SIZE_RST;
  logic [2:0]         reg_stride = mp2d_pkg::STRIDE_RST;
  logic [6:0]         reg_height = mp2d_pkg::IN_HEIGHT_RST;
  logic [6:0]         reg_width  = mp2d_pkg::IN_WIDTH_RST;
  logic [6:0]         reg_chans  = mp2d_pkg::CHANNELS_RST;
  logic signed [15:0] line_buf [STORE_WORDS];
  int unsigned        pos_row, pos_col, pos_chan;
  pooled_t            max_queue [$];

  // run bookkeeping
  int unsigned error_count     = 0;
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned configs_used    = 0;
  bit          idle_on         = 1'b1;
  bit          hold_on         = 1'b0;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // generous fixed limit, far above the slowest legal run
  initial begin : watchdog
    #8000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch: %s", what);
  endtask

  // zero reads as one, anything above the cap saturates
  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned buf_addr(input int unsigned r, input int unsigned c,
                                           input int unsigned ch);
    return ((r % POOL_CAP) * WIDTH_CAP + (c % WIDTH_CAP)) * CHAN_CAP + (ch % CHAN_CAP);
  endfunction

  function automatic int unsigned image_items();
    return clamp_dim(reg_height, mp2d_pkg::HEIGHT_LIMIT) * clamp_dim(reg_width, WIDTH_CAP)
           * clamp_dim(reg_chans, CHAN_CAP);
  endfunction

  // store one element, and when it closes a window queue that window's maximum
  task automatic pool_sample(input logic [15:0] v);
    int unsigned        p, s, h, w, c, top, left, i, j, last_r, last_c;
    logic signed [15:0] best, cur;
    pooled_t            res;
    p = clamp_dim(reg_pool, POOL_CAP);
    s = clamp_dim(reg_stride, STRIDE_CAP);
    h = clamp_dim(reg_height, mp2d_pkg::HEIGHT_LIMIT);
    w = clamp_dim(reg_width, WIDTH_CAP);
    c = clamp_dim(reg_chans, CHAN_CAP);
    line_buf[buf_addr(pos_row, pos_col, pos_chan)] = v;
    if (pos_row + 1 >= p && pos_col + 1 >= p &&
        (pos_row + 1 - p) % s == 0 && (pos_col + 1 - p) % s == 0) begin
      top  = pos_row + 1 - p;
      left = pos_col + 1 - p;
      best = line_buf[buf_addr(top, left, pos_chan)];
      for (i = 0; i < p; i++) begin
        for (j = 0; j < p; j++) begin
          cur = line_buf[buf_addr(top + i, left + j, pos_chan)];
          if (cur > best) best = cur;
        end
      end
      res.value = best;
      res.last  = 1'b0;
      if (h >= p && w >= p) begin
        last_r   = ((h - p) / s) * s + p - 1;
        last_c   = ((w - p) / s) * s + p - 1;
        res.last = (pos_row == last_r && pos_col == last_c && pos_chan + 1 == c);
      end
      max_queue.push_back(res);
    end
    // channel innermost, then column, then row
    pos_chan++;
    if (pos_chan >= c) begin
      pos_chan = 0;
      pos_col++;
      if (pos_col >= w) begin
        pos_col = 0;
        pos_row++;
        if (pos_row >= h) pos_row = 0;
      end
    end
  endtask

  // offer one element, after a random gap when gaps are on, return once the transfer happened
  task automatic send_sample(input logic [15:0] v);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= v;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    items_sent++;
    pool_sample(v);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 8)) - 16'd4;  // near zero, lots of ties
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver side: random stalls per result, the long hold, and the result check
  initial begin : result_sink
    int      sink_gap;
    pooled_t want;
    sink_gap    = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_on) begin
        out_ready_i <= 1'b0;
      end else if (sink_gap > 0) begin
        out_ready_i <= 1'b0;
        sink_gap--;
      end else begin
        out_ready_i <= 1'b1;
      end
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        if (max_queue.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", pooled_value_o));
        end else begin
          want = max_queue.pop_front();
          if (pooled_value_o !== want.value)
            report_mismatch($sformatf("pooled value %h, expected %h",
                                      pooled_value_o, want.value));
          if (image_done_o !== want.last)
            report_mismatch($sformatf("image done %b, expected %b on value %h",
                                      image_done_o, want.last, want.value));
          results_checked++;
        end
        sink_gap = idle_on ? $urandom_range(0, 3) : 0;
      end
    end
  end

  // one apb transfer, setup then access, read data taken at the completing edge
  task automatic apb_transfer(input logic wr, input logic [2:0] idx,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] rd;
    apb_transfer(1'b0, idx, '0, rd);
    if (rd !== want)
      report_mismatch($sformatf("register %0d reads %h, expected %h", idx, rd, want));
  endtask

  // drop valid, wait for every expected result and for the block to go quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (max_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // counters sit at an image start here, so no window ever spans two settings
  task automatic set_config(input int unsigned p, input int unsigned s, input int unsigned h,
                            input int unsigned w, input int unsigned c);
    logic [PDATA_W-1:0] rd;
    settle();
    reg_pool   = p[2:0];
    reg_stride = s[2:0];
    reg_height = h[6:0];
    reg_width  = w[6:0];
    reg_chans  = c[6:0];
    apb_transfer(1'b1, mp2d_pkg::REG_WIN_SIZE, PDATA_W'(reg_pool), rd);
    apb_transfer(1'b1, mp2d_pkg::REG_STRIDE, PDATA_W'(reg_stride), rd);
    apb_transfer(1'b1, mp2d_pkg::REG_IN_HEIGHT, PDATA_W'(reg_height), rd);
    apb_transfer(1'b1, mp2d_pkg::REG_IN_WIDTH, PDATA_W'(reg_width), rd);
    apb_transfer(1'b1, mp2d_pkg::REG_CHANNELS, PDATA_W'(reg_chans), rd);
    check_reg(mp2d_pkg::REG_WIN_SIZE, PDATA_W'(reg_pool));
    check_reg(mp2d_pkg::REG_STRIDE, PDATA_W'(reg_stride));
    check_reg(mp2d_pkg::REG_IN_HEIGHT, PDATA_W'(reg_height));
    check_reg(mp2d_pkg::REG_IN_WIDTH, PDATA_W'(reg_width));
    check_reg(mp2d_pkg::REG_CHANNELS, PDATA_W'(reg_chans));
    configs_used++;
  endtask

  task automatic test_register_defaults();
    check_reg(mp2d_pkg::REG_WIN_SIZE, PDATA_W'(mp2d_pkg::WIN_SIZE_RST));
    check_reg(mp2d_pkg::REG_STRIDE, PDATA_W'(mp2d_pkg::STRIDE_RST));
    check_reg(mp2d_pkg::REG_IN_HEIGHT, PDATA_W'(mp2d_pkg::IN_HEIGHT_RST));
    check_reg(mp2d_pkg::REG_IN_WIDTH, PDATA_W'(mp2d_pkg::IN_WIDTH_RST));
    check_reg(mp2d_pkg::REG_CHANNELS, PDATA_W'(mp2d_pkg::CHANNELS_RST));
  endtask

  // a single 2x2 window holding both extremes of the sample range
  task automatic test_sample_extremes();
    set_config(2, 2, 2, 2, 1);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'hffff);
    send_sample(16'h0000);
  endtask

  // all-zero registers act as ones: every element is its own 1x1 image
  task automatic test_zero_registers();
    set_config(0, 0, 0, 0, 0);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0100);
  endtask

  // window larger than the image: nothing comes out, no image done either
  task automatic test_window_exceeds_image();
    set_config(3, 1, 2, 2, 1);
    repeat (4) send_sample(pick_sample());
  endtask

  // pool above range saturates, stride at its top value; negative-only data in the window
  task automatic test_oversized_pool();
    set_config(7, 7, 4, 4, 1);
    repeat (16) send_sample(16'h8000 | 16'($urandom));
  endtask

  // height, width and channel caps, each on a small image
  task automatic test_size_limits();
    set_config(1, 7, 127, 1, 1);
    repeat (image_items()) send_sample(pick_sample());
    set_config(2, 2, 2, 127, 3);
    repeat (image_items()) send_sample(pick_sample());
    set_config(2, 1, 2, 2, 127);
    repeat (image_items()) send_sample(pick_sample());
  endtask

  // receiver stalls for a long stretch while the sender keeps pushing
  task automatic test_receiver_hold();
    set_config(2, 1, 6, 6, 2);
    idle_on = 1'b0;
    hold_on = 1'b1;
    fork
      begin : long_hold
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_on = 1'b0;
      end
    join_none
    repeat (image_items()) send_sample(pick_sample());
    idle_on = 1'b1;
  endtask

  function automatic int unsigned pick_window();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
  endfunction

  function automatic int unsigned pick_dim(input int unsigned hi);
    return ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, hi);
  endfunction

  // whole images under random settings, gaps on or off per setting
  task automatic test_random_images();
    int unsigned first, n_img;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      set_config(pick_window(), pick_window(), pick_dim(12), pick_dim(12), pick_dim(6));
      idle_on = ($urandom_range(0, 3) != 0);
      n_img   = $urandom_range(1, 3);
      repeat (n_img * image_items()) send_sample(pick_sample());
    end
    idle_on = 1'b1;
  endtask

  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    sample_i   = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    pos_row    = 0;
    pos_col    = 0;
    pos_chan   = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_defaults();
    test_sample_extremes();
    test_zero_registers();
    test_window_exceeds_image();
    test_oversized_pool();
    test_size_limits();
    test_receiver_hold();
    test_random_images();
    settle();

    $display("run: %0d samples over %0d register settings, %0d pooled results checked",
             items_sent, configs_used, results_checked);
    $display("run: corner values, clamped registers, size caps, long stall, random images");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
